>>> rtl/core/stfl_pkg.sv
package stfl_pkg;

  // Table geometry and field widths.
  localparam int unsigned SLOTS         = 1024;
  localparam int unsigned IDX_W         = $clog2(SLOTS);
  localparam int unsigned CNT_W         = IDX_W + 1;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned MIN_REQUEST   = 8;
  localparam int unsigned MAX_REQUEST   = SLOTS - 1;
  localparam int unsigned RESET_REQUEST = 8;
  localparam logic [1:0]  ALIGN_MASK    = 2'h3;

  // Stream payload layout.
  localparam int unsigned IN_FIELDS_W  = WORD_W + IDX_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned IN_PAD_W     = IN_TDATA_W - IN_FIELDS_W;
  localparam int unsigned OUT_FIELDS_W = IDX_W + WORD_W + CNT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT    = 2'd0,
    MODE_INSERT_AT = 2'd1,
    MODE_REMOVE    = 2'd2,
    MODE_PEEK      = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_FULL       = 3'd2,
    ST_RANGE      = 3'd3,
    ST_FREE       = 3'd4
  } status_e;

  // One slot of the table: free flag, free-list link and stored word.
  typedef struct packed {
    logic              free;
    logic [IDX_W-1:0]  link;
    logic [WORD_W-1:0] word;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Microprogram.
  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t U_IDLE     = upc_t'(0);
  localparam upc_t U_CHECK    = upc_t'(1);
  localparam upc_t U_BRANCH   = upc_t'(2);
  localparam upc_t U_WALK_EXH = upc_t'(3);
  localparam upc_t U_WALK_FND = upc_t'(4);
  localparam upc_t U_WALK_ADV = upc_t'(5);
  localparam upc_t U_RELINK   = upc_t'(6);
  localparam upc_t U_TAKE     = upc_t'(7);
  localparam upc_t U_SLOT     = upc_t'(8);
  localparam upc_t U_PUSH     = upc_t'(9);
  localparam upc_t U_OUT      = upc_t'(10);

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACC,
    C_ERR,
    C_MODE_HI,
    C_EXH,
    C_FOUND,
    C_NO_PUSH,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_CHECK,
    RD_LINK
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_TAKE,
    WR_RELINK,
    WR_PUSH
  } wr_sel_e;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_INIT,
    DP_WALK,
    DP_ADVANCE,
    DP_TAKE,
    DP_SLOT,
    DP_PUSH,
    DP_OUT
  } dp_op_e;

  typedef struct packed {
    cond_e   cond;
    upc_t    target;
    logic    last;
    rd_sel_e rd;
    wr_sel_e wr;
    dp_op_e  dp;
  } ucode_t;

  // Conditions that the datapath reports to the sequencer.
  typedef struct packed {
    logic no_acc;
    logic err;
    logic mode_hi;
    logic exh;
    logic found;
    logic no_push;
    logic out_busy;
  } cond_flags_t;

  function automatic ucode_t uword(cond_e cond, upc_t target, logic last,
                                   rd_sel_e rd, wr_sel_e wr, dp_op_e dp);
    ucode_t w;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    w.rd     = rd;
    w.wr     = wr;
    w.dp     = dp;
    return w;
  endfunction

  // The relink of the predecessor comes before the take, so that the free count is
  // still the one the walk was bounded by while the walk step is active.
  function automatic ucode_t ucode_rom(upc_t pc);
    ucode_t w;
    unique case (pc)
      U_IDLE:     w = uword(C_NO_ACC,   U_IDLE,     1'b0, RD_NONE,  WR_NONE,   DP_IDLE);
      U_CHECK:    w = uword(C_ERR,      U_OUT,      1'b0, RD_CHECK, WR_NONE,   DP_INIT);
      U_BRANCH:   w = uword(C_MODE_HI,  U_SLOT,     1'b0, RD_NONE,  WR_NONE,   DP_WALK);
      U_WALK_EXH: w = uword(C_EXH,      U_OUT,      1'b0, RD_NONE,  WR_NONE,   DP_WALK);
      U_WALK_FND: w = uword(C_FOUND,    U_RELINK,   1'b0, RD_NONE,  WR_NONE,   DP_WALK);
      U_WALK_ADV: w = uword(C_ALWAYS,   U_WALK_EXH, 1'b0, RD_LINK,  WR_NONE,   DP_ADVANCE);
      U_RELINK:   w = uword(C_NEVER,    U_IDLE,     1'b0, RD_NONE,  WR_RELINK, DP_WALK);
      U_TAKE:     w = uword(C_ALWAYS,   U_OUT,      1'b0, RD_NONE,  WR_TAKE,   DP_TAKE);
      U_SLOT:     w = uword(C_NO_PUSH,  U_OUT,      1'b0, RD_NONE,  WR_NONE,   DP_SLOT);
      U_PUSH:     w = uword(C_NEVER,    U_IDLE,     1'b0, RD_NONE,  WR_PUSH,   DP_PUSH);
      U_OUT:      w = uword(C_OUT_BUSY, U_OUT,      1'b1, RD_NONE,  WR_NONE,   DP_OUT);
      default:    w = uword(C_ALWAYS,   U_IDLE,     1'b0, RD_NONE,  WR_NONE,   DP_WALK);
    endcase
    return w;
  endfunction

  // Number of active slots for a requested capacity.
  function automatic logic [CNT_W-1:0] active_from_request(logic [IDX_W-1:0] req);
    logic [CNT_W-1:0] r;
    r = {1'b0, req};
    if (r < CNT_W'(MIN_REQUEST)) begin
      r = CNT_W'(MIN_REQUEST);
    end else if (r > CNT_W'(MAX_REQUEST)) begin
      r = CNT_W'(MAX_REQUEST);
    end
    return r + CNT_W'(1);
  endfunction

endpackage

>>> rtl/core/stfl_ram.sv
module stfl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/stfl_useq.sv
module stfl_useq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stfl_pkg::cond_flags_t flags_i,
  output stfl_pkg::ucode_t     uw_o
);

  stfl_pkg::upc_t   upc_q, upc_d;
  stfl_pkg::ucode_t uw;
  logic             taken;

  assign uw   = stfl_pkg::ucode_rom(upc_q);
  assign uw_o = uw;

  always_comb begin
    unique case (uw.cond)
      stfl_pkg::C_NEVER:    taken = 1'b0;
      stfl_pkg::C_ALWAYS:   taken = 1'b1;
      stfl_pkg::C_NO_ACC:   taken = flags_i.no_acc;
      stfl_pkg::C_ERR:      taken = flags_i.err;
      stfl_pkg::C_MODE_HI:  taken = flags_i.mode_hi;
      stfl_pkg::C_EXH:      taken = flags_i.exh;
      stfl_pkg::C_FOUND:    taken = flags_i.found;
      stfl_pkg::C_NO_PUSH:  taken = flags_i.no_push;
      stfl_pkg::C_OUT_BUSY: taken = flags_i.out_busy;
      default:              taken = 1'b1;
    endcase
  end

  always_comb begin
    if (taken) begin
      upc_d = uw.target;
    end else if (uw.last) begin
      upc_d = stfl_pkg::U_IDLE;
    end else begin
      upc_d = stfl_pkg::upc_t'(upc_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= stfl_pkg::U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> rtl/core/slot_table_free_list_unit.sv
// Slot table with a free list threaded through its free slots. The table holds
// requested_size+1 active slots (requested_size clamped to 8..1023), each a
// 32-bit object word, in one single-port-read, single-port-write RAM whose
// entries also carry the free flag and the free-list link. A short microprogram
// drives the datapath one step per cycle unless the result stream stalls, so
// the block works on one request at a time. An insert steps through check,
// branch, walk, relink, take and output, a remove through check, branch, slot,
// push and output, a peek through check, branch, slot and output, and a request
// rejected at the first check (misaligned word, full table, index out of range)
// from check to output; then the idle step comes before the next request is
// taken. Insert-at walks the free list with an exhaustion check, a found check
// and an advance per link passed over, until a free slot at or above the
// requested index is found; a walk that finds none ends after all free slots
// have been visited. The walk rate is set by the RAM's registered read, one
// link per read. After reset, and after every write of requested_size, the
// free list is rebuilt by a pass that writes one slot per cycle through every
// active slot; no request is taken during that pass, but requested_size may be written.
module slot_table_free_list_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: requested_size.
  input  logic                            cfg_we_i,
  input  logic [stfl_pkg::IDX_W-1:0]      cfg_wdata_i,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata fields, low bit up: object_word[31:0], slot_index[41:32], zero pad.
  input  logic [stfl_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // tuser fields: mode[1:0].
  input  logic [stfl_pkg::MODE_W-1:0]     s_axis_tuser,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata fields, low bit up: result_index[9:0], result_word[41:10],
  // used_count[52:42], zero pad.
  output logic [stfl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser fields: status[2:0].
  output logic [stfl_pkg::STATUS_W-1:0]   m_axis_tuser
);

  localparam int unsigned IDX_W  = stfl_pkg::IDX_W;
  localparam int unsigned CNT_W  = stfl_pkg::CNT_W;
  localparam int unsigned WORD_W = stfl_pkg::WORD_W;

  // Sequencer.
  stfl_pkg::ucode_t      uw;
  stfl_pkg::cond_flags_t flags;

  // Request registers.
  stfl_pkg::mode_e   mode_q, mode_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  // Walk registers.
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] prev_q, prev_d;
  logic             has_prev_q, has_prev_d;
  logic [CNT_W-1:0] n_q, n_d;

  // Free-list control state.
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] fcnt_q, fcnt_d;
  logic [CNT_W-1:0] active_q, active_d;
  logic             clr_q, clr_d;
  logic [IDX_W-1:0] clr_addr_q, clr_addr_d;
  logic [CNT_W-1:0] clr_next;

  // Result being built.
  stfl_pkg::status_e status_q, status_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic [WORD_W-1:0] res_word_q, res_word_d;

  // Output register.
  logic              m_valid_q, m_valid_d;
  stfl_pkg::status_e m_status_q, m_status_d;
  logic [IDX_W-1:0]  m_idx_q, m_idx_d;
  logic [WORD_W-1:0] m_word_q, m_word_d;
  logic [CNT_W-1:0]  m_used_q, m_used_d;

  // RAM ports.
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  stfl_pkg::entry_t              ram_wdata;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [stfl_pkg::ENTRY_W-1:0]  ram_rdata;
  stfl_pkg::entry_t              rd;

  logic              in_xfer;
  logic              out_busy;
  stfl_pkg::status_e err_status;

  assign rd = stfl_pkg::entry_t'(ram_rdata);

  stfl_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uw_o    (uw)
  );

  stfl_ram #(
    .WIDTH (stfl_pkg::ENTRY_W),
    .DEPTH (stfl_pkg::SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Requests are taken only in the idle step and outside the rebuild pass.
  assign s_axis_tready = (uw.dp == stfl_pkg::DP_IDLE) && !clr_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_busy      = m_valid_q && !m_axis_tready;

  // First check of a request: alignment and fullness for inserts, range for
  // remove and peek.
  always_comb begin
    err_status = stfl_pkg::ST_OK;
    if (!mode_q[1]) begin
      if ((word_q[1:0] & stfl_pkg::ALIGN_MASK) != 2'b00) begin
        err_status = stfl_pkg::ST_MISALIGNED;
      end else if (fcnt_q == '0) begin
        err_status = stfl_pkg::ST_FULL;
      end
    end else if ({1'b0, idx_q} >= active_q) begin
      err_status = stfl_pkg::ST_RANGE;
    end
  end

  always_comb begin
    flags.no_acc   = !in_xfer;
    flags.err      = (err_status != stfl_pkg::ST_OK);
    flags.mode_hi  = mode_q[1];
    flags.exh      = (n_q >= fcnt_q);
    flags.found    = (mode_q == stfl_pkg::MODE_INSERT) || (cur_q >= idx_q);
    flags.no_push  = rd.free || (mode_q == stfl_pkg::MODE_PEEK);
    flags.out_busy = out_busy;
  end

  // The rebuild pass writes the ascending chain; the last active slot links
  // back to slot zero, which is harmless as the walk is bounded by the count.
  assign clr_next = {1'b0, clr_addr_q} + CNT_W'(1);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = head_q;
    unique case (uw.rd)
      stfl_pkg::RD_NONE: begin
        ram_re = 1'b0;
      end
      stfl_pkg::RD_CHECK: begin
        ram_re    = 1'b1;
        ram_raddr = mode_q[1] ? idx_q : head_q;
      end
      stfl_pkg::RD_LINK: begin
        ram_re    = 1'b1;
        ram_raddr = rd.link;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = clr_addr_q;
    ram_wdata.free = 1'b1;
    ram_wdata.link = '0;
    ram_wdata.word = '0;
    if (clr_q) begin
      ram_we         = 1'b1;
      ram_wdata.link = (clr_next < active_q) ? clr_next[IDX_W-1:0] : '0;
    end else begin
      unique case (uw.wr)
        stfl_pkg::WR_NONE: begin
          ram_we = 1'b0;
        end
        stfl_pkg::WR_TAKE: begin
          // The taken slot becomes occupied with the new word.
          ram_we         = 1'b1;
          ram_waddr      = cur_q;
          ram_wdata.free = 1'b0;
          ram_wdata.word = word_q;
        end
        stfl_pkg::WR_RELINK: begin
          // The predecessor, still free, skips over the taken slot.
          ram_we         = has_prev_q;
          ram_waddr      = prev_q;
          ram_wdata.link = rd.link;
        end
        stfl_pkg::WR_PUSH: begin
          // The removed slot goes to the head of the free list.
          ram_we         = 1'b1;
          ram_waddr      = idx_q;
          ram_wdata.link = head_q;
          ram_wdata.word = rd.word;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  // Datapath next state.
  always_comb begin
    mode_d     = mode_q;
    word_d     = word_q;
    idx_d      = idx_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    has_prev_d = has_prev_q;
    n_d        = n_q;
    head_d     = head_q;
    fcnt_d     = fcnt_q;
    active_d   = active_q;
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    status_d   = status_q;
    res_idx_d  = res_idx_q;
    res_word_d = res_word_q;

    unique case (uw.dp)
      stfl_pkg::DP_IDLE: begin
        if (in_xfer) begin
          mode_d = stfl_pkg::mode_e'(s_axis_tuser);
          word_d = s_axis_tdata[WORD_W-1:0];
          idx_d  = s_axis_tdata[WORD_W +: IDX_W];
        end
      end
      stfl_pkg::DP_INIT: begin
        cur_d      = head_q;
        has_prev_d = 1'b0;
        n_d        = '0;
        status_d   = err_status;
        res_idx_d  = '0;
        res_word_d = '0;
      end
      stfl_pkg::DP_WALK: begin
        if (flags.exh && !mode_q[1]) begin
          status_d = stfl_pkg::ST_FULL;
        end
      end
      stfl_pkg::DP_ADVANCE: begin
        prev_d     = cur_q;
        cur_d      = rd.link;
        has_prev_d = 1'b1;
        n_d        = n_q + CNT_W'(1);
      end
      stfl_pkg::DP_TAKE: begin
        if (!has_prev_q) begin
          head_d = rd.link;
        end
        fcnt_d    = fcnt_q - CNT_W'(1);
        res_idx_d = cur_q;
      end
      stfl_pkg::DP_SLOT: begin
        if (rd.free) begin
          status_d = stfl_pkg::ST_FREE;
        end else begin
          res_word_d = rd.word;
        end
      end
      stfl_pkg::DP_PUSH: begin
        head_d = idx_q;
        fcnt_d = fcnt_q + CNT_W'(1);
      end
      stfl_pkg::DP_OUT: begin
        status_d = status_q;
      end
      default: begin
        status_d = status_q;
      end
    endcase

    if (clr_q) begin
      clr_addr_d = clr_addr_q + IDX_W'(1);
      if (clr_next == active_q) begin
        clr_d = 1'b0;
      end
    end

    // A write of requested_size empties the table and restarts the rebuild.
    if (cfg_we_i) begin
      active_d   = stfl_pkg::active_from_request(cfg_wdata_i);
      fcnt_d     = active_d;
      head_d     = '0;
      clr_d      = 1'b1;
      clr_addr_d = '0;
    end
  end

  // Output register: loaded in the last step once the previous result is gone.
  always_comb begin
    m_valid_d  = m_valid_q;
    m_status_d = m_status_q;
    m_idx_d    = m_idx_q;
    m_word_d   = m_word_q;
    m_used_d   = m_used_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if ((uw.dp == stfl_pkg::DP_OUT) && !out_busy) begin
      m_valid_d  = 1'b1;
      m_status_d = status_q;
      m_idx_d    = res_idx_q;
      m_word_d   = res_word_q;
      m_used_d   = active_q - fcnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      active_q   <= stfl_pkg::active_from_request(IDX_W'(stfl_pkg::RESET_REQUEST));
      fcnt_q     <= stfl_pkg::active_from_request(IDX_W'(stfl_pkg::RESET_REQUEST));
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      m_valid_q  <= 1'b0;
      has_prev_q <= 1'b0;
      n_q        <= '0;
    end else begin
      head_q     <= head_d;
      active_q   <= active_d;
      fcnt_q     <= fcnt_d;
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      m_valid_q  <= m_valid_d;
      has_prev_q <= has_prev_d;
      n_q        <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    word_q     <= word_d;
    idx_q      <= idx_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    status_q   <= status_d;
    res_idx_q  <= res_idx_d;
    res_word_q <= res_word_d;
    m_status_q <= m_status_d;
    m_idx_q    <= m_idx_d;
    m_word_q   <= m_word_d;
    m_used_q   <= m_used_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{stfl_pkg::OUT_PAD_W{1'b0}}, m_used_q, m_word_q, m_idx_q};

endmodule

>>> test/tb_slot_table_free_list_unit.sv
module tb_slot_table_free_list_unit;
  import stfl_pkg::*;

  // A stretch with no transfer on either side longer than this means the block has hung.
  // The slowest legitimate quiet spell is a failed insert-at walk over a 1024-slot table,
  // a rebuild pass or the long output hold-off.
  localparam int unsigned QUIET_LIMIT     = 20000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned MAX_REPORTS     = 20;

  // One result as the block should present it.
  typedef struct {
    status_e           status;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  used;
  } outcome_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [IDX_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [MODE_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  slot_table_free_list_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the table. It is updated at the moment a request transfer is
  // accepted, so the stimulus can also consult it to aim removes at occupied slots.
  logic [WORD_W-1:0] shadow_word [SLOTS];
  bit                shadow_free [SLOTS];
  int unsigned       shadow_link [SLOTS];
  int unsigned       shadow_head;
  int unsigned       shadow_free_count;
  int unsigned       live_slots;

  outcome_t    awaited_outcomes [$];
  outcome_t    oldest_outcome;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned sender_gap_pct  = 0;
  int unsigned receiver_stall_pct = 0;
  logic        holding_off     = 1'b0;
  event        hold_off_start;

  // Empties the table and threads the free list through the active slots in
  // ascending order, exactly as a write of requested_size does in the block.
  function automatic void rebuild_free_chain(logic [IDX_W-1:0] req);
    int unsigned clamped;
    clamped = req;
    if (clamped < MIN_REQUEST) clamped = MIN_REQUEST;
    if (clamped > MAX_REQUEST) clamped = MAX_REQUEST;
    live_slots = clamped + 1;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_free[i] = 1'b1;
      shadow_link[i] = (i + 1 < live_slots) ? i + 1 : 0;
    end
    shadow_head       = 0;
    shadow_free_count = live_slots;
  endfunction

  // Applies one request to the shadow table and returns the result it must produce.
  // Insert-at follows the free list in list order, not index order, so the slot it
  // takes depends on the history of removes.
  function automatic outcome_t table_outcome(mode_e mode, logic [WORD_W-1:0] obj,
                                             logic [IDX_W-1:0] idx);
    outcome_t    r;
    int unsigned cur;
    int unsigned prev;
    int unsigned visited;
    bit          has_prev;
    bit          found;
    r.status = ST_OK;
    r.index  = '0;
    r.word   = '0;
    if (mode == MODE_INSERT || mode == MODE_INSERT_AT) begin
      if ((obj[1:0] & ALIGN_MASK) != '0) begin
        r.status = ST_MISALIGNED;
      end else if (shadow_free_count == 0) begin
        r.status = ST_FULL;
      end else begin
        cur      = shadow_head;
        prev     = 0;
        visited  = 0;
        has_prev = 1'b0;
        found    = 1'b0;
        while (!found && visited < shadow_free_count) begin
          if (mode == MODE_INSERT || cur >= idx) begin
            found = 1'b1;
          end else begin
            prev     = cur;
            has_prev = 1'b1;
            cur      = shadow_link[cur];
            visited++;
          end
        end
        if (!found) begin
          r.status = ST_FULL;
        end else begin
          if (has_prev) shadow_link[prev] = shadow_link[cur];
          else shadow_head = shadow_link[cur];
          shadow_word[cur] = obj;
          shadow_free[cur] = 1'b0;
          shadow_free_count--;
          r.index = IDX_W'(cur);
        end
      end
    end else begin
      if (idx >= live_slots) begin
        r.status = ST_RANGE;
      end else if (shadow_free[idx]) begin
        r.status = ST_FREE;
      end else begin
        r.word = shadow_word[idx];
        if (mode == MODE_REMOVE) begin
          shadow_link[idx] = shadow_head;
          shadow_head      = idx;
          shadow_free[idx] = 1'b1;
          shadow_free_count++;
        end
      end
    end
    r.used = CNT_W'(live_slots - shadow_free_count);
    return r;
  endfunction

  // Prints a bounded number of mismatch lines but counts every one.
  task automatic report_mismatch(string field, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at result %0d: %s is 0x%0h, expected 0x%0h",
               results_checked, field, got, want);
    end
  endtask

  // Offers one request and waits for its transfer. Valid is left high afterwards,
  // so a following request in the same time step simply replaces the payload; it is
  // only lowered when the sender chooses to pause or when a phase ends.
  task automatic send_request(mode_e mode, logic [WORD_W-1:0] obj, logic [IDX_W-1:0] idx);
    if (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{IN_PAD_W{1'b0}}, idx, obj};
    do @(posedge clk_i); while (!s_axis_tready);
    awaited_outcomes.push_back(table_outcome(mode, obj, idx));
    requests_sent++;
  endtask

  // Ends a phase: drops valid and waits for every outstanding result.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // requested_size is only written with the block idle.
  task automatic write_table_size(logic [IDX_W-1:0] req);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= req;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rebuild_free_chain(req);
  endtask

  task automatic set_idling(int unsigned gap_pct, int unsigned stall_pct);
    sender_gap_pct     = gap_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // Mostly well-formed traffic: aligned words, in-range indices, and removes and
  // peeks aimed at occupied slots, weighted towards inserts so that small tables
  // fill up and the full cases are reached. The rest is misaligned words and
  // indices anywhere in the field's range.
  task automatic send_random_requests(int unsigned count);
    int unsigned       pick;
    mode_e             mode;
    logic [WORD_W-1:0] obj;
    logic [IDX_W-1:0]  idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) mode = MODE_INSERT;
      else if (pick < 58) mode = MODE_INSERT_AT;
      else if (pick < 80) mode = MODE_REMOVE;
      else mode = MODE_PEEK;
      obj = $urandom;
      if ($urandom_range(0, 9) != 0) obj[1:0] = 2'b00;
      if ($urandom_range(0, 9) == 0) idx = IDX_W'($urandom_range(0, SLOTS - 1));
      else idx = IDX_W'($urandom_range(0, live_slots - 1));
      if ((mode == MODE_REMOVE || mode == MODE_PEEK) && idx < live_slots &&
          $urandom_range(0, 2) != 0) begin
        for (int t = 0; t < 16 && shadow_free[idx]; t++) begin
          idx = IDX_W'($urandom_range(0, live_slots - 1));
        end
      end
      send_request(mode, obj, idx);
    end
  endtask

  // Reset geometry of nine slots: alignment checks on both inserts, range and free
  // slot errors, a remove followed by an insert-at that walks the free list, an
  // insert-at with no slot high enough, and filling the table to full.
  task automatic test_directed_cases();
    logic [WORD_W-1:0] obj;
    set_idling(0, 0);
    send_request(MODE_INSERT,    32'h0000_0000, '0);
    send_request(MODE_INSERT,    32'hFFFF_FFFF, '0);
    send_request(MODE_INSERT_AT, 32'h0000_0001, '0);
    send_request(MODE_INSERT_AT, 32'h0000_0002, '0);
    send_request(MODE_INSERT,    32'hFFFF_FFFC, 10'h3FF);
    send_request(MODE_PEEK,      '0, 10'd0);
    send_request(MODE_PEEK,      '0, 10'd1);
    send_request(MODE_PEEK,      '0, 10'd5);
    send_request(MODE_REMOVE,    '0, 10'd5);
    send_request(MODE_PEEK,      '0, 10'h3FF);
    send_request(MODE_REMOVE,    '0, 10'd9);
    send_request(MODE_REMOVE,    '0, 10'd0);
    send_request(MODE_INSERT_AT, 32'hA5A5_A5A4, 10'd4);
    send_request(MODE_INSERT_AT, 32'h5A5A_5A58, 10'h3FF);
    send_request(MODE_INSERT_AT, 32'h1234_5678, 10'd8);
    // Six slots remain free; the seventh insert finds the table full.
    for (int i = 0; i < 7; i++) begin
      obj      = $urandom;
      obj[1:0] = 2'b00;
      send_request(MODE_INSERT, obj, IDX_W'($urandom));
    end
    send_request(MODE_INSERT_AT, 32'h0000_0010, 10'd0);
    // A misaligned word is reported as such even when the table is full.
    send_request(MODE_INSERT,    32'h0000_0003, '0);
    send_request(MODE_REMOVE,    '0, 10'd8);
    send_request(MODE_PEEK,      '0, 10'd8);
  endtask

  // Small tables, including a request below the minimum that must be clamped,
  // each run through all four idling phases.
  task automatic test_random_small_tables();
    logic [IDX_W-1:0] sizes [4];
    sizes = '{10'd0, 10'd8, 10'd13, 10'd31};
    for (int s = 0; s < 4; s++) begin
      write_table_size(sizes[s]);
      set_idling(0, 0);
      send_random_requests(20);
      set_idling(72, 0);
      send_random_requests(20);
      set_idling(0, 72);
      send_random_requests(20);
      set_idling(30, 30);
      send_random_requests(20);
    end
  endtask

  // The largest table: every bit of requested_size set and long insert-at walks.
  task automatic test_largest_table();
    write_table_size(10'h3FF);
    set_idling(30, 30);
    send_random_requests(40);
  endtask

  task automatic test_midsize_table();
    write_table_size(10'd200);
    set_idling(72, 0);
    send_random_requests(20);
    set_idling(0, 72);
    send_random_requests(20);
  endtask

  // The receiver refuses results for a long stretch while requests keep coming,
  // so the block backs up and has to hold its input off.
  task automatic test_output_hold_off();
    write_table_size(10'd8);
    set_idling(0, 0);
    -> hold_off_start;
    send_random_requests(24);
  endtask

  // Long hold-off, counted here so the stimulus carries on regardless.
  initial begin
    forever begin
      @(hold_off_start);
      holding_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      holding_off <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !holding_off && ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Every result transfer is compared field by field with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("result with no request outstanding, status",
                        WORD_W'(m_axis_tuser), '0);
      end else begin
        oldest_outcome = awaited_outcomes.pop_front();
        if (m_axis_tuser !== oldest_outcome.status)
          report_mismatch("status", WORD_W'(m_axis_tuser), WORD_W'(oldest_outcome.status));
        if (m_axis_tdata[IDX_W-1:0] !== oldest_outcome.index)
          report_mismatch("result_index", WORD_W'(m_axis_tdata[IDX_W-1:0]),
                          WORD_W'(oldest_outcome.index));
        if (m_axis_tdata[IDX_W +: WORD_W] !== oldest_outcome.word)
          report_mismatch("result_word", m_axis_tdata[IDX_W +: WORD_W], oldest_outcome.word);
        if (m_axis_tdata[IDX_W + WORD_W +: CNT_W] !== oldest_outcome.used)
          report_mismatch("used_count", WORD_W'(m_axis_tdata[IDX_W + WORD_W +: CNT_W]),
                          WORD_W'(oldest_outcome.used));
      end
    end
  end

  // Watchdog: any transfer on either side counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("slot_table_free_list_unit verification failed");
      $finish;
    end
  end

  initial begin
    rebuild_free_chain(IDX_W'(RESET_REQUEST));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_random_small_tables();
    test_largest_table();
    test_midsize_table();
    test_output_hold_off();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d results from %0d requests over tables of 9 to 1024 slots.",
             results_checked, requests_sent);
    $display("Traffic ran back to back, with sender gaps, receiver stalls and a long hold-off.");
    if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
      $display("slot_table_free_list_unit verification clean");
    end else begin
      $display("slot_table_free_list_unit verification failed");
    end
    $finish;
  end

endmodule
